// ===== design/scfc_pkg.sv =====
// Shared types, codes and the CRC-16 byte update for the frame checker.
package scfc_pkg;

  // Register indexes on the configuration port
  localparam logic [7:0] REG_SYNC_FIRST  = 8'd0;
  localparam logic [7:0] REG_SYNC_SECOND = 8'd1;

  // CRC-16/CCITT-FALSE constants
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;
  localparam int unsigned QCNT_W      = 2;

  // Verdict codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_LINK = 2'd1,
    STAT_SYNC = 2'd2,
    STAT_CRC  = 2'd3
  } status_e;

  // Role of a byte within its frame
  typedef enum logic [1:0] {
    KIND_BODY   = 2'd0,
    KIND_CRC_LO = 2'd1,
    KIND_LAST   = 2'd2
  } kind_e;

  // One classified request passed from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       err;
    logic       sync_bad;
    kind_e      kind;
  } item_t;

  // Fold one byte into the running CRC, MSB first
  function automatic logic [15:0] crc_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/sync_crc_frame_checker_unit.sv =====
// Top level of the sync and CRC-16 frame checker.
//
//  channel  direction  handshake                request payload
//  cfg      in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//  in       in         in_valid_i/in_ready_o    rx_byte_i, link_error_i
//  out      out        out_valid_o/out_ready_i  frame_status_o, computed_crc_o,
//                                               received_crc_o, have_valid_o
//
// One byte per cycle sustained while results are taken; the byte-wide CRC update in the back stage sets it.
// A verdict is registered in the output register when the back end takes the last byte of a frame from the queue.
// Reset clears the frame position, the CRC state and the sticky valid flag.
// A stalled result holds in the output register; the two-entry queue keeps
// taking bytes until it fills. Configuration writes are taken every cycle.
module sync_crc_frame_checker_unit #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  input  logic        link_error_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  frame_status_o,
  output logic [15:0] computed_crc_o,
  output logic [15:0] received_crc_o,
  output logic        have_valid_o
);
  import scfc_pkg::*;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  scfc_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .link_error_i (link_error_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_item_o  (push_item)
  );

  scfc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  scfc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (pop_valid),
    .pop_ready_o    (pop_ready),
    .pop_item_i     (pop_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_status_o (frame_status_o),
    .computed_crc_o (computed_crc_o),
    .received_crc_o (received_crc_o),
    .have_valid_o   (have_valid_o)
  );

endmodule

// ===== design/scfc_front.sv =====
// Front end: accepts bytes, tracks frame position, checks sync bytes.
module scfc_front #(
  parameter int unsigned FRAME_BYTES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          rx_byte_i,
  input  logic                link_error_i,
  output logic                push_valid_o,
  input  logic                push_ready_i,
  output scfc_pkg::item_t     push_item_o
);
  import scfc_pkg::*;

  localparam int unsigned IdxW = $clog2(FRAME_BYTES);
  localparam logic [IdxW-1:0] IdxLast  = IdxW'(FRAME_BYTES - 1);
  localparam logic [IdxW-1:0] IdxCrcLo = IdxW'(FRAME_BYTES - 2);

  logic [7:0]      sync_first_q, sync_second_q;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            accept;

  // Configuration writes are always taken; unknown indexes drop
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= 8'h00;
      sync_second_q <= 8'h00;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_SYNC_FIRST) begin
        sync_first_q <= cfg_data_i;
      end else if (cfg_index_i == REG_SYNC_SECOND) begin
        sync_second_q <= cfg_data_i;
      end
    end
  end

  // Accept whenever the queue has room
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;
  assign accept       = in_valid_i && push_ready_i;

  // Classify the byte by its position
  always_comb begin
    push_item_o.data     = rx_byte_i;
    push_item_o.err      = link_error_i;
    push_item_o.sync_bad = ((idx_q == '0) && (rx_byte_i != sync_first_q)) ||
                           ((idx_q == IdxW'(1)) && (rx_byte_i != sync_second_q));
    if (idx_q == IdxLast) begin
      push_item_o.kind = KIND_LAST;
    end else if (idx_q == IdxCrcLo) begin
      push_item_o.kind = KIND_CRC_LO;
    end else begin
      push_item_o.kind = KIND_BODY;
    end
  end

  // Advance position, wrap after the last byte
  always_comb begin
    idx_d = idx_q;
    if (accept) begin
      idx_d = (idx_q == IdxLast) ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== design/scfc_queue.sv =====
// Short queue of classified requests between front and back.
module scfc_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  scfc_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output scfc_pkg::item_t pop_item_o
);
  import scfc_pkg::*;

  item_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = slot_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Track occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
    end
  end

  // Store pushed requests
  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_item_i;
    end
  end

endmodule

// ===== design/scfc_back.sv =====
// Back end: runs the CRC, forms the verdict and holds the result register.
module scfc_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  output logic            pop_ready_o,
  input  scfc_pkg::item_t pop_item_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      frame_status_o,
  output logic [15:0]     computed_crc_o,
  output logic [15:0]     received_crc_o,
  output logic            have_valid_o
);
  import scfc_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic        err_q, err_d;
  logic        sync_ok_q, sync_ok_d;
  logic [7:0]  lo_q, lo_d;
  logic        seen_q, seen_d;
  logic        out_valid_q, out_valid_d;
  logic        load;
  logic        err_all;
  logic [15:0] rx_crc;
  status_e     status;

  // Take a request when the result register is free or draining
  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign load        = pop_valid_i && pop_ready_o;

  assign err_all = err_q || pop_item_i.err;
  assign rx_crc  = {pop_item_i.data, lo_q};

  // Verdict: link error, then sync, then CRC
  always_comb begin
    if (err_all) begin
      status = STAT_LINK;
    end else if (!sync_ok_q || pop_item_i.sync_bad) begin
      status = STAT_SYNC;
    end else if (rx_crc != crc_q) begin
      status = STAT_CRC;
    end else begin
      status = STAT_OK;
    end
  end

  // Update per-frame state
  always_comb begin
    crc_d       = crc_q;
    err_d       = err_q;
    sync_ok_d   = sync_ok_q;
    lo_d        = lo_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      err_d     = err_all;
      sync_ok_d = sync_ok_q && !pop_item_i.sync_bad;
      case (pop_item_i.kind)
        KIND_BODY: begin
          crc_d = crc_add_byte(crc_q, pop_item_i.data);
        end
        KIND_CRC_LO: begin
          lo_d = pop_item_i.data;
        end
        KIND_LAST: begin
          out_valid_d = 1'b1;
          seen_d      = seen_q || (status == STAT_OK);
          crc_d       = CRC_INIT;
          err_d       = 1'b0;
          sync_ok_d   = 1'b1;
          lo_d        = 8'h00;
        end
        default: begin
          crc_d = crc_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CRC_INIT;
      err_q       <= 1'b0;
      sync_ok_q   <= 1'b1;
      lo_q        <= 8'h00;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      crc_q       <= crc_d;
      err_q       <= err_d;
      sync_ok_q   <= sync_ok_d;
      lo_q        <= lo_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the result on the last byte
  always_ff @(posedge clk_i) begin
    if (load && (pop_item_i.kind == KIND_LAST)) begin
      frame_status_o <= status;
      computed_crc_o <= crc_q;
      received_crc_o <= rx_crc;
      have_valid_o   <= seen_q || (status == STAT_OK);
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== design/scfc_checker.sv =====
// Port-level assertions for the frame checker and their bind.
module scfc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  frame_status_o,
  input logic [15:0] computed_crc_o,
  input logic [15:0] received_crc_o,
  input logic        have_valid_o
);
  import scfc_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(frame_status_o) && $stable(computed_crc_o)
      && $stable(received_crc_o) && $stable(have_valid_o))
    else $error("stalled result changed");

  // A passing frame sets the sticky flag
  a_ok_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o == STAT_OK) |-> have_valid_o)
    else $error("ok verdict without valid flag");

  // CRC verdicts agree with the reported CRC values
  a_ok_crc_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o == STAT_OK) |-> computed_crc_o == received_crc_o)
    else $error("ok verdict with CRC mismatch");

  a_bad_crc_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_status_o == STAT_CRC) |-> computed_crc_o != received_crc_o)
    else $error("bad CRC verdict with matching CRC");

endmodule

bind sync_crc_frame_checker_unit scfc_checker u_scfc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .frame_status_o (frame_status_o),
  .computed_crc_o (computed_crc_o),
  .received_crc_o (received_crc_o),
  .have_valid_o   (have_valid_o)
);

// ===== tb/sv/scfc_verdict_monitor.sv =====
`timescale 1ns / 100ps
// CRC-16 byte fold for the testbench and the monitor that predicts and checks frame verdicts.
package scfc_tb_pkg;
  import scfc_pkg::*;

  // Shift one byte into a CRC-16 register bit by bit, MSB first
  function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] octet);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ octet[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

endpackage

module scfc_verdict_monitor
  import scfc_pkg::*;
  import scfc_tb_pkg::*;
#(
  parameter int unsigned FRAME_LEN = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        link_error_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  frame_status_i,
  input  logic [15:0] computed_crc_i,
  input  logic [15:0] received_crc_i,
  input  logic        have_valid_i,
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_o
);

  typedef struct {
    status_e     status;
    logic [15:0] calc_crc;
    logic [15:0] frame_crc;
    logic        sticky;
  } verdict_t;

  verdict_t    verdict_q[$];

  // Shadow copy of the sync registers and the per-frame state
  logic [7:0]  sync_a;
  logic [7:0]  sync_b;
  int unsigned byte_pos;
  logic [15:0] crc_run;
  logic        sync_ok;
  logic        link_bad;
  logic [7:0]  crc_lo;
  logic        ever_valid;

  always @(posedge clk_i or negedge rst_ni) begin : track
    verdict_t    want;
    logic [15:0] carried;
    if (!rst_ni) begin
      sync_a           = 8'h00;
      sync_b           = 8'h00;
      byte_pos         = 0;
      crc_run          = CRC_INIT;
      sync_ok          = 1'b1;
      link_bad         = 1'b0;
      crc_lo           = 8'h00;
      ever_valid       = 1'b0;
      verdict_q.delete();
      mismatch_count_o = 0;
      outstanding_o    = 0;
    end else begin
      // Apply register writes; drop writes to unknown indexes
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == REG_SYNC_FIRST) begin
          sync_a = cfg_data_i;
        end else if (cfg_index_i == REG_SYNC_SECOND) begin
          sync_b = cfg_data_i;
        end
      end

      // Retire the oldest predicted verdict against the block's output
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          $error("verdict with none expected: status %0d computed %h received %h valid %b",
                 frame_status_i, computed_crc_i, received_crc_i, have_valid_i);
          mismatch_count_o++;
        end else begin
          want = verdict_q.pop_front();
          if (frame_status_i !== want.status) begin
            $error("frame_status: expected %0d, actual %0d", want.status, frame_status_i);
            mismatch_count_o++;
          end
          if (computed_crc_i !== want.calc_crc) begin
            $error("computed_crc: expected %h, actual %h", want.calc_crc, computed_crc_i);
            mismatch_count_o++;
          end
          if (received_crc_i !== want.frame_crc) begin
            $error("received_crc: expected %h, actual %h", want.frame_crc, received_crc_i);
            mismatch_count_o++;
          end
          if (have_valid_i !== want.sticky) begin
            $error("have_valid: expected %b, actual %b", want.sticky, have_valid_i);
            mismatch_count_o++;
          end
        end
      end

      // Fold an accepted byte into the frame state; predict a verdict on the last byte
      if (in_valid_i && in_ready_i) begin
        if (link_error_i) link_bad = 1'b1;
        if (byte_pos == 0 && rx_byte_i != sync_a) sync_ok = 1'b0;
        if (byte_pos == 1 && rx_byte_i != sync_b) sync_ok = 1'b0;
        if (byte_pos + 2 < FRAME_LEN) crc_run = crc16_fold(crc_run, rx_byte_i);
        if (byte_pos + 2 == FRAME_LEN) crc_lo = rx_byte_i;
        if (byte_pos + 1 < FRAME_LEN) begin
          byte_pos++;
        end else begin
          carried = {rx_byte_i, crc_lo};
          if (link_bad) begin
            want.status = STAT_LINK;
          end else if (!sync_ok) begin
            want.status = STAT_SYNC;
          end else if (carried != crc_run) begin
            want.status = STAT_CRC;
          end else begin
            want.status = STAT_OK;
          end
          if (want.status == STAT_OK) ever_valid = 1'b1;
          want.calc_crc  = crc_run;
          want.frame_crc = carried;
          want.sticky    = ever_valid;
          verdict_q.push_back(want);
          // Restart the frame; the sticky flag survives
          byte_pos = 0;
          crc_run  = CRC_INIT;
          sync_ok  = 1'b1;
          link_bad = 1'b0;
          crc_lo   = 8'h00;
        end
      end

      outstanding_o = verdict_q.size();
    end
  end

endmodule

// ===== tb/sv/sync_crc_frame_checker_unit_tb.sv =====
`timescale 1ns / 100ps
// Top of the frame checker testbench: clock, reset, frame stimulus, receiver stalls and verdict.
module sync_crc_frame_checker_unit_tb;
  import scfc_pkg::*;
  import scfc_tb_pkg::*;

  localparam int unsigned FRAME_LEN        = 32;
  localparam int unsigned CLK_PERIOD       = 10;
  localparam int unsigned RESET_CYCLES     = 6;
  // Covers bytes still in the queue after the last predicted verdict
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned HOLD_CYCLES      = 300;
  // Longest legal quiet stretch is the receiver hold-off plus a sender gap
  localparam int unsigned QUIET_LIMIT      = 3000;
  localparam int unsigned PHASES           = 5;
  localparam int unsigned FRAMES_PER_PHASE = 8;

  typedef enum int {FR_GOOD, FR_BAD_FIRST, FR_BAD_SECOND, FR_BAD_CRC, FR_LINK, FR_NOISE} flavor_e;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  rx_byte_i;
  logic        link_error_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  frame_status_o;
  logic [15:0] computed_crc_o;
  logic [15:0] received_crc_o;
  logic        have_valid_o;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned quiet_cycles = 0;

  // Frame under construction and the sync values last written
  logic [7:0]  frame_bytes[FRAME_LEN];
  logic        frame_errs[FRAME_LEN];
  logic [7:0]  cur_first;
  logic [7:0]  cur_second;
  int unsigned burst_left;
  bit          squeeze_req;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  sync_crc_frame_checker_unit #(
    .FRAME_BYTES(FRAME_LEN)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .rx_byte_i     (rx_byte_i),
    .link_error_i  (link_error_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .frame_status_o(frame_status_o),
    .computed_crc_o(computed_crc_o),
    .received_crc_o(received_crc_o),
    .have_valid_o  (have_valid_o)
  );

  scfc_verdict_monitor #(
    .FRAME_LEN(FRAME_LEN)
  ) u_monitor (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .link_error_i    (link_error_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_status_i  (frame_status_o),
    .computed_crc_i  (computed_crc_o),
    .received_crc_i  (received_crc_o),
    .have_valid_i    (have_valid_o),
    .mismatch_count_o(mismatches),
    .outstanding_o   (outstanding)
  );

  // Write one register, then drop the request
  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_SYNC_FIRST) begin
      cur_first = val;
    end else if (idx == REG_SYNC_SECOND) begin
      cur_second = val;
    end
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Fill the frame buffer: sync bytes, payload, trailing CRC, then the requested damage
  task automatic build_frame(input flavor_e flavor, input bit fixed_fill, input logic [7:0] fill);
    logic [15:0] crc;
    int unsigned bit_sel;
    for (int unsigned k = 0; k < FRAME_LEN; k++) begin
      frame_bytes[k] = fixed_fill ? fill : 8'($urandom);
      frame_errs[k]  = 1'b0;
    end
    frame_bytes[0] = cur_first;
    frame_bytes[1] = cur_second;
    if (flavor == FR_BAD_FIRST) frame_bytes[0] = cur_first ^ 8'($urandom_range(1, 255));
    if (flavor == FR_BAD_SECOND) frame_bytes[1] = cur_second ^ 8'($urandom_range(1, 255));
    crc = CRC_INIT;
    for (int unsigned k = 0; k + 2 < FRAME_LEN; k++) begin
      crc = crc16_fold(crc, frame_bytes[k]);
    end
    frame_bytes[FRAME_LEN-2] = crc[7:0];
    frame_bytes[FRAME_LEN-1] = crc[15:8];
    case (flavor)
      FR_BAD_CRC: begin
        bit_sel = $urandom_range(0, 15);
        if (bit_sel < 8) begin
          frame_bytes[FRAME_LEN-2][bit_sel] = ~frame_bytes[FRAME_LEN-2][bit_sel];
        end else begin
          frame_bytes[FRAME_LEN-1][bit_sel-8] = ~frame_bytes[FRAME_LEN-1][bit_sel-8];
        end
      end
      FR_LINK: begin
        frame_errs[$urandom_range(0, FRAME_LEN - 1)] = 1'b1;
      end
      FR_NOISE: begin
        for (int unsigned k = 0; k < FRAME_LEN; k++) begin
          frame_bytes[k] = 8'($urandom);
          frame_errs[k]  = ($urandom_range(0, 15) == 0);
        end
      end
      default: begin
      end
    endcase
  endtask

  // Offer frame bytes lo..hi in bursts with random gaps between them
  task automatic push_range(input int unsigned lo, input int unsigned hi);
    int unsigned gap;
    for (int unsigned k = lo; k <= hi; k++) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 256)
                                                 : $urandom_range(1, 24);
        gap = $urandom_range(1, 6);
        repeat (gap) begin
          @(negedge clk_i);
          in_valid_i = 1'b0;
        end
      end
      @(negedge clk_i);
      in_valid_i   = 1'b1;
      rx_byte_i    = frame_bytes[k];
      link_error_i = frame_errs[k];
      do @(posedge clk_i); while (!in_ready_o);
      burst_left--;
    end
  endtask

  // Stop sending, wait for every predicted verdict, then let the pipeline drain
  task automatic settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    flavor_e     flavor;
    int unsigned roll;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = 8'h00;
    cfg_data_i   = 8'h00;
    in_valid_i   = 1'b0;
    rx_byte_i    = 8'h00;
    link_error_i = 1'b0;
    cur_first    = 8'h00;
    cur_second   = 8'h00;
    burst_left   = 0;
    squeeze_req  = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Sync values reset to zero: a zero-filled frame with its CRC passes
    build_frame(FR_GOOD, 1'b1, 8'h00);
    push_range(0, FRAME_LEN - 1);
    settle();
    write_reg(REG_SYNC_FIRST, 8'hFF);
    write_reg(REG_SYNC_SECOND, 8'hFF);
    build_frame(FR_GOOD, 1'b1, 8'hFF);
    push_range(0, FRAME_LEN - 1);
    // Bad first sync byte wins over a bad CRC
    build_frame(FR_BAD_FIRST, 1'b0, 8'h00);
    frame_bytes[FRAME_LEN-1] = frame_bytes[FRAME_LEN-1] ^ 8'h80;
    push_range(0, FRAME_LEN - 1);
    // Link error on the last byte wins over a bad second sync byte
    build_frame(FR_BAD_SECOND, 1'b0, 8'h00);
    frame_errs[FRAME_LEN-1] = 1'b1;
    push_range(0, FRAME_LEN - 1);
    build_frame(FR_BAD_CRC, 1'b0, 8'h00);
    push_range(0, FRAME_LEN - 1);
    // Link error on the first byte of an otherwise clean frame
    build_frame(FR_GOOD, 1'b0, 8'h00);
    frame_errs[0] = 1'b1;
    push_range(0, FRAME_LEN - 1);
    // Writes past the register list must leave the sync values alone
    settle();
    write_reg(8'd2, 8'h00);
    write_reg(8'hFF, 8'h00);
    build_frame(FR_GOOD, 1'b0, 8'h00);
    push_range(0, FRAME_LEN - 1);
    // A second sync value written after byte 0 applies to byte 1 of the same frame
    cur_second = 8'h5A;
    build_frame(FR_GOOD, 1'b0, 8'h00);
    push_range(0, 0);
    settle();
    write_reg(REG_SYNC_SECOND, 8'h5A);
    push_range(1, FRAME_LEN - 1);

    // Random phases, each under its own sync setting
    for (int unsigned p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(REG_SYNC_FIRST, 8'h00);
          write_reg(REG_SYNC_SECOND, 8'hFF);
        end
        1: begin
          write_reg(REG_SYNC_FIRST, 8'hFF);
          write_reg(REG_SYNC_SECOND, 8'h00);
        end
        default: begin
          write_reg(REG_SYNC_FIRST, 8'($urandom));
          write_reg(REG_SYNC_SECOND, 8'($urandom));
        end
      endcase
      if (p == 3) write_reg(8'($urandom_range(2, 255)), 8'($urandom));
      // Hold the receiver off while this phase streams in
      if (p == 1) squeeze_req = 1'b1;
      for (int unsigned f = 0; f < FRAMES_PER_PHASE; f++) begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          flavor = FR_GOOD;
        end else if (roll < 63) begin
          flavor = FR_BAD_FIRST;
        end else if (roll < 71) begin
          flavor = FR_BAD_SECOND;
        end else if (roll < 80) begin
          flavor = FR_BAD_CRC;
        end else if (roll < 88) begin
          flavor = FR_LINK;
        end else begin
          flavor = FR_NOISE;
        end
        build_frame(flavor, 1'b0, 8'h00);
        push_range(0, FRAME_LEN - 1);
      end
    end

    settle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("** sync_crc_frame_checker_unit: PASSED **");
    end else begin
      $display("** sync_crc_frame_checker_unit: FAILED **");
    end
    $finish;
  end

  // Receiver: switch among stall patterns; one long hold-off on request
  initial begin : receiver
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned cadence;
    bit          squeezed;
    mode        = RX_OPEN;
    mode_left   = 0;
    hold_left   = 0;
    cadence     = 0;
    squeezed    = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (squeeze_req && !squeezed) begin
        squeezed  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      cadence++;
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   out_ready_i = 1'b1;
          RX_COIN:   out_ready_i = $urandom_range(0, 1);
          RX_SPARSE: out_ready_i = ($urandom_range(0, 3) == 0);
          default:   out_ready_i = (cadence % 3 != 0);
        endcase
      end
    end
  end

  // End the run when no request of any kind moves for too long
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("** sync_crc_frame_checker_unit: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
